### hdl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/mgma_pkg.sv
package mgma_pkg;

	localparam int TIME_W   = 32;
	localparam int SAMPLE_W = 16;
	localparam int LIMIT_W  = 15;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_LIMIT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_LEVEL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_TOL   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_LIMIT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STILL_TIME    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_DELAY    = 3'd5;

	localparam logic [LIMIT_W-1:0] RST_ACCEL_LIMIT   = 15'd84;
	localparam logic [LIMIT_W-1:0] RST_GRAVITY_LEVEL = 15'd4093;
	localparam logic [LIMIT_W-1:0] RST_GRAVITY_TOL   = 15'd209;
	localparam logic [LIMIT_W-1:0] RST_GYRO_LIMIT    = 15'd188;
	localparam logic [TIME_W-1:0]  RST_STILL_TIME    = 32'd1000;
	localparam logic [TIME_W-1:0]  RST_STOP_DELAY    = 32'd1000;

	localparam logic MODE_WRIST  = 1'b0;
	localparam logic MODE_FINGER = 1'b1;

	typedef struct packed {
		logic                       mode;
		logic [TIME_W-1:0]          time_ms;
		logic signed [SAMPLE_W-1:0] accel_x;
		logic signed [SAMPLE_W-1:0] accel_y;
		logic signed [SAMPLE_W-1:0] accel_z;
		logic signed [SAMPLE_W-1:0] gyro_x;
		logic signed [SAMPLE_W-1:0] gyro_y;
		logic signed [SAMPLE_W-1:0] gyro_z;
	} in_item_t;

	typedef struct packed {
		logic motor_drive;
		logic wrist_confirmed;
		logic sample_still;
	} out_item_t;

	// Classified sample handed from front to back
	typedef struct packed {
		logic              mode;
		logic [TIME_W-1:0] time_ms;
		logic              still;
	} cls_item_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] accel_limit;
		logic [LIMIT_W-1:0] gravity_level;
		logic [LIMIT_W-1:0] gravity_tolerance;
		logic [LIMIT_W-1:0] gyro_limit;
		logic [TIME_W-1:0]  still_time_ms;
		logic [TIME_W-1:0]  stop_delay_ms;
	} cfg_t;

endpackage

### hdl/mgma_front.sv
`include "assert_macros.svh"

module mgma_front (
	input  logic               clk,
	input  logic               arst_n,
	input  mgma_pkg::cfg_t     cfg,
	input  logic               in_valid,
	output logic               in_stall,
	input  mgma_pkg::in_item_t in_data,
	output logic               cls_valid,
	input  logic               cls_stall,
	output mgma_pkg::cls_item_t cls_data
);
	import mgma_pkg::*;

	localparam int MAG_W = SAMPLE_W + 1;

	function automatic logic [MAG_W-1:0] mag(input logic signed [MAG_W-1:0] v);
		mag = v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
	endfunction

	logic                    valid_s1;
	cls_item_t               item_s1;
	logic signed [MAG_W-1:0] dz;
	logic [MAG_W-1:0]        acc_lim;
	logic [MAG_W-1:0]        grav_tol;
	logic [MAG_W-1:0]        gyr_lim;
	logic                    still;
	logic                    take;

	always_comb begin
		acc_lim  = MAG_W'(cfg.accel_limit);
		grav_tol = MAG_W'(cfg.gravity_tolerance);
		gyr_lim  = MAG_W'(cfg.gyro_limit);
		dz = MAG_W'(in_data.accel_z) - $signed(MAG_W'(cfg.gravity_level));
		still = (mag(MAG_W'(in_data.accel_x)) < acc_lim) &&
			(mag(MAG_W'(in_data.accel_y)) < acc_lim) &&
			(mag(dz) < grav_tol) &&
			(mag(MAG_W'(in_data.gyro_x)) < gyr_lim) &&
			(mag(MAG_W'(in_data.gyro_y)) < gyr_lim) &&
			(mag(MAG_W'(in_data.gyro_z)) < gyr_lim);
	end

	// hold the stage while the queue is full
	assign in_stall  = valid_s1 && cls_stall;
	assign take      = in_valid && !in_stall;
	assign cls_valid = valid_s1;
	assign cls_data  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (!cls_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.mode    <= in_data.mode;
			item_s1.time_ms <= in_data.time_ms;
			item_s1.still   <= still;
		end
	end

	`ASSERT_CLK(a_front_hold, (valid_s1 && cls_stall) |=> (valid_s1 && $stable(item_s1)), "front stage dropped a stalled sample")
	`ASSERT_CLK(a_front_load, take |=> valid_s1, "accepted sample not captured")

endmodule

### hdl/mgma_queue.sv
`include "assert_macros.svh"

module mgma_queue #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_stall,
	input  mgma_pkg::cls_item_t push_data,
	output logic                pop_valid,
	input  logic                pop_stall,
	output mgma_pkg::cls_item_t pop_data
);
	import mgma_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);

	cls_item_t        mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_stall = (count_q == FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && !pop_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	`ASSERT_CLK(a_queue_bound, count_q <= FULL, "queue count beyond depth")
	`ASSERT_CLK(a_queue_grow, (push && !pop) |=> (count_q == CNT_W'($past(count_q) + 1'b1)), "queue count did not advance on transfer in")

endmodule

### hdl/mgma_back.sv
`include "assert_macros.svh"

module mgma_back (
	input  logic                clk,
	input  logic                arst_n,
	input  mgma_pkg::cfg_t      cfg,
	input  logic                cls_valid,
	output logic                cls_stall,
	input  mgma_pkg::cls_item_t cls_data,
	output logic                out_valid,
	input  logic                out_stall,
	output mgma_pkg::out_item_t out_data
);
	import mgma_pkg::*;

	logic [TIME_W-1:0] still_start_q;
	logic              still_timing_q;
	logic              wrist_stat_q;
	logic              motor_q;
	logic [TIME_W-1:0] stop_start_q;
	logic              out_valid_q;
	out_item_t         out_data_q;

	logic [TIME_W-1:0] still_start_d;
	logic              still_timing_d;
	logic              wrist_stat_d;
	logic              motor_d;
	logic [TIME_W-1:0] stop_start_d;
	logic [TIME_W-1:0] elapsed;
	logic              take;

	assign take      = cls_valid && (!out_valid_q || !out_stall);
	assign cls_stall = !take;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		still_start_d  = still_start_q;
		still_timing_d = still_timing_q;
		wrist_stat_d   = wrist_stat_q;
		motor_d        = motor_q;
		stop_start_d   = stop_start_q;
		elapsed        = '0;
		if (cls_data.mode == MODE_WRIST) begin
			if (cls_data.still) begin
				if (!wrist_stat_q) begin
					// start the stillness run on its first sample
					if (!still_timing_q) begin
						still_start_d = cls_data.time_ms;
					end
					still_timing_d = 1'b1;
					elapsed = cls_data.time_ms - still_start_d;
					if (elapsed >= cfg.still_time_ms) begin
						wrist_stat_d = 1'b1;
					end
				end
			end else begin
				still_timing_d = 1'b0;
				if (wrist_stat_q) begin
					wrist_stat_d = 1'b0;
					if (motor_q) begin
						stop_start_d = cls_data.time_ms;
					end
				end
			end
		end else begin
			if (wrist_stat_q && !cls_data.still) begin
				motor_d = 1'b1;
			end
			elapsed = cls_data.time_ms - stop_start_q;
			if (motor_d && !wrist_stat_q && (elapsed >= cfg.stop_delay_ms)) begin
				motor_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			still_start_q  <= '0;
			still_timing_q <= 1'b0;
			wrist_stat_q   <= 1'b0;
			motor_q        <= 1'b0;
			stop_start_q   <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (take) begin
				still_start_q  <= still_start_d;
				still_timing_q <= still_timing_d;
				wrist_stat_q   <= wrist_stat_d;
				motor_q        <= motor_d;
				stop_start_q   <= stop_start_d;
				out_valid_q    <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_data_q.motor_drive     <= motor_d;
			out_data_q.wrist_confirmed <= wrist_stat_d;
			out_data_q.sample_still    <= cls_data.still;
		end
	end

	`ASSERT_CLK(a_back_wrist_motor, (take && (cls_data.mode == MODE_WRIST)) |=> (motor_q == $past(motor_q)), "motor changed on a wrist sample")
	`ASSERT_CLK(a_back_finger_wrist, (take && (cls_data.mode == MODE_FINGER)) |=> (wrist_stat_q == $past(wrist_stat_q)), "wrist state changed on a finger sample")

endmodule

### hdl/motion_gated_motor_alert_core.sv
// Motion-gated motor alert. Each transfer on the input channel is one 6-axis
// IMU sample (wrist or finger, by mode) with a millisecond timestamp, and each
// produces exactly one result: the motor level, the wrist-confirmed flag and
// whether the sample itself was still. The block sustains one sample per clock
// cycle while the output is not stalled. A result passes through the
// classification register, which loads at the accepting edge, then the queue
// and the output register. The queue lets the classifier keep accepting while
// the output is stalled, until the queue is full. The user must write
// thresholds and times on the configuration port only while the block is
// idle; the block itself does not enforce this.
module motion_gated_motor_alert_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [mgma_pkg::CFG_IDX_W-1:0]        cfg_addr,
	input  logic [mgma_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  mgma_pkg::in_item_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output mgma_pkg::out_item_t                  out_data
);
	import mgma_pkg::*;

	cfg_t      cfg_q;
	logic      cls_valid;
	logic      cls_stall;
	cls_item_t cls_data;
	logic      q_valid;
	logic      q_stall;
	cls_item_t q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel_limit       <= RST_ACCEL_LIMIT;
			cfg_q.gravity_level     <= RST_GRAVITY_LEVEL;
			cfg_q.gravity_tolerance <= RST_GRAVITY_TOL;
			cfg_q.gyro_limit        <= RST_GYRO_LIMIT;
			cfg_q.still_time_ms     <= RST_STILL_TIME;
			cfg_q.stop_delay_ms     <= RST_STOP_DELAY;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				CFG_ACCEL_LIMIT: begin
					cfg_q.accel_limit <= cfg_wdata[LIMIT_W-1:0];
				end
				CFG_GRAVITY_LEVEL: begin
					cfg_q.gravity_level <= cfg_wdata[LIMIT_W-1:0];
				end
				CFG_GRAVITY_TOL: begin
					cfg_q.gravity_tolerance <= cfg_wdata[LIMIT_W-1:0];
				end
				CFG_GYRO_LIMIT: begin
					cfg_q.gyro_limit <= cfg_wdata[LIMIT_W-1:0];
				end
				CFG_STILL_TIME: begin
					cfg_q.still_time_ms <= cfg_wdata[TIME_W-1:0];
				end
				CFG_STOP_DELAY: begin
					cfg_q.stop_delay_ms <= cfg_wdata[TIME_W-1:0];
				end
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

	mgma_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.cls_valid (cls_valid),
		.cls_stall (cls_stall),
		.cls_data  (cls_data)
	);

	mgma_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (cls_valid),
		.push_stall (cls_stall),
		.push_data  (cls_data),
		.pop_valid  (q_valid),
		.pop_stall  (q_stall),
		.pop_data   (q_data)
	);

	mgma_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cls_valid (q_valid),
		.cls_stall (q_stall),
		.cls_data  (q_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
